### hw/rtl/tsct_pkg.sv
// Shared types and constants of the series sine, cosine and tangent block.
// Holds the request and result payload structs, function and status codes.
// No dependencies.
`timescale 1ns / 1ps

package tsct_pkg;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] angle;
    logic [3:0]         term_count;
  } req_t;

  typedef struct packed {
    logic signed [47:0] value;
    logic [1:0]         status;
  } rsp_t;

  localparam logic [1:0] SEL_SIN  = 2'd0;
  localparam logic [1:0] SEL_COS  = 2'd1;
  localparam logic [1:0] SEL_TAN  = 2'd2;
  localparam logic [1:0] SEL_NONE = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZDIV = 2'd2;

  localparam int FRAC_IN   = 27;
  localparam int FRAC_WORK = 32;

  localparam logic [63:0] POS_LIMIT = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h0000_8000_0000_0000;

endpackage

### hw/rtl/taylor_sin_cos_tan_top.sv
// Top level of the series sine, cosine and tangent block: sequencer, shared
// multiplier, term divider and tangent divider. Depends on tsct_pkg.
`timescale 1ns / 1ps

// A request carries the function wanted (sine, cosine or tangent), an angle in
// radians as signed Q4.27 and a term count N. The block sums the Maclaurin
// series over n = 0..N, building each term x^k/k! from the previous one as
// t*|x|/k rounded half up, and returns one Q20.27 result with a status
// (ok, saturated, or tangent with a zero cosine sum). A term count above
// MAX_TERMS is treated as MAX_TERMS. The block works on one request at a
// time: it is ready only when idle, and holds the result until the transfer
// on the result channel completes. Every term k = 1..2N+1 passes through one
// 32x32 multiplier (two passes, low and high part of the term) and a divider
// by k that retires eight quotient bits a cycle. Tangent then runs a
// one-bit-per-cycle restoring division of the two sums, 91 steps. The unused
// selector code answers zero with status ok in the cycle after the request.
module taylor_sin_cos_tan_top #(
  parameter int MAX_TERMS = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tsct_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tsct_pkg::rsp_t rsp
);

  // Width of the term index k, which runs up to 2*MAX_TERMS+1.
  localparam int KW        = $clog2(2 * MAX_TERMS + 2);
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = 64 / DIV_BITS;
  localparam int DCW       = $clog2(DIV_STEPS);
  localparam int TDIV_LEN  = 64 + tsct_pkg::FRAC_IN;
  localparam int TCW       = $clog2(TDIV_LEN);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL_LO = 4'd1;
  localparam logic [3:0] S_MUL_HI = 4'd2;
  localparam logic [3:0] S_ADD    = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_ACC    = 4'd5;
  localparam logic [3:0] S_FIN    = 4'd6;
  localparam logic [3:0] S_TDIV   = 4'd7;
  localparam logic [3:0] S_TEMIT  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]    state;
  logic [1:0]    sel;
  logic          xneg;
  logic [31:0]   ax;
  logic [KW-1:0] k;
  logic [KW-1:0] kmax;
  logic [63:0]   t;
  logic [63:0]   sin_sum;
  logic [63:0]   cos_sum;
  logic [63:0]   p;
  logic [36:0]   rnd;
  logic [63:0]   dvd;
  logic [KW-1:0] rem;
  logic [DCW-1:0] dcnt;
  logic [63:0]   num;
  logic [63:0]   dvs;
  logic [63:0]   trem;
  logic [47:0]   q;
  logic          ovf;
  logic          tneg;
  logic [TCW-1:0] tcnt;
  tsct_pkg::rsp_t rsp_q;

  logic [31:0]   mul_a;
  logic [63:0]   prod;
  logic [63:0]   dvd_next;
  logic [KW-1:0] rem_next;
  logic [63:0]   trem_next;
  logic          tbit;
  logic [KW-1:0] kmax_next;
  logic          minus;
  logic [63:0]   sum_sel;
  logic [63:0]   sc_mag;
  logic [63:0]   us;
  logic [63:0]   uc;

  // Saturate a sign and magnitude into the 48-bit result.
  function automatic tsct_pkg::rsp_t emit(input logic neg, input logic [63:0] mag);
    tsct_pkg::rsp_t r;
    logic [63:0]    m;
    logic [63:0]    v;
    m = mag;
    r.status = tsct_pkg::ST_OK;
    if (!neg && mag > tsct_pkg::POS_LIMIT) begin
      m = tsct_pkg::POS_LIMIT;
      r.status = tsct_pkg::ST_SAT;
    end
    if (neg && mag > tsct_pkg::NEG_LIMIT) begin
      m = tsct_pkg::NEG_LIMIT;
      r.status = tsct_pkg::ST_SAT;
    end
    v = neg ? (64'd0 - m) : m;
    r.value = v[47:0];
    return r;
  endfunction

  // Shared multiplier: low 27 fraction bits of the term, then the 32 bits above them.
  assign mul_a = (state == S_MUL_LO) ? {5'd0, t[26:0]} : t[58:27];
  assign prod  = {32'd0, mul_a} * {32'd0, ax};

  // Divider by k: eight restoring steps on a narrow remainder per cycle.
  always_comb begin
    logic [KW:0]   r2;
    logic [KW-1:0] r;
    logic [63:0]   d;
    r = rem;
    d = dvd;
    for (int i = 0; i < DIV_BITS; i++) begin
      r2 = {r, d[63]};
      d  = {d[62:0], 1'b0};
      if (r2 >= {1'b0, k}) begin
        r2   = r2 - {1'b0, k};
        d[0] = 1'b1;
      end
      r = r2[KW-1:0];
    end
    dvd_next = d;
    rem_next = r;
  end

  // Tangent divider: one quotient bit per cycle.
  always_comb begin
    logic [64:0] r2;
    r2 = {trem, num[63]};
    if (r2 >= {1'b0, dvs}) begin
      r2   = r2 - {1'b0, dvs};
      tbit = 1'b1;
    end else begin
      tbit = 1'b0;
    end
    trem_next = r2[63:0];
  end

  // Highest term index 2N+1 after clamping N to MAX_TERMS.
  always_comb begin
    if (32'(req.term_count) > 32'(MAX_TERMS)) begin
      kmax_next = KW'(2 * MAX_TERMS + 1);
    end else begin
      kmax_next = KW'(2 * 32'(req.term_count) + 1);
    end
  end

  // Odd terms go to the sine sum and follow the sign of x; n is k/2.
  assign minus   = k[0] ? (k[1] ^ xneg) : k[1];
  assign sum_sel = (sel == tsct_pkg::SEL_SIN) ? sin_sum : cos_sum;
  assign sc_mag  = ((sum_sel[63] ? (64'd0 - sum_sel) : sum_sel) + 64'd16) >> 5;
  assign us      = sin_sum[63] ? (64'd0 - sin_sum) : sin_sum;
  assign uc      = cos_sum[63] ? (64'd0 - cos_sum) : cos_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            sel     <= req.req_type;
            xneg    <= req.angle[31];
            ax      <= req.angle[31] ? (32'd0 - req.angle) : req.angle;
            kmax    <= kmax_next;
            k       <= KW'(1);
            t       <= 64'd1 << tsct_pkg::FRAC_WORK;
            sin_sum <= 64'd0;
            cos_sum <= 64'd1 << tsct_pkg::FRAC_WORK;
            if (req.req_type == tsct_pkg::SEL_NONE) begin
              rsp_q.value  <= 48'd0;
              rsp_q.status <= tsct_pkg::ST_OK;
              state        <= S_DONE;
            end else begin
              state <= S_MUL_LO;
            end
          end
        end
        S_MUL_LO: begin
          p     <= prod;
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          rnd   <= 37'((p + (64'd1 << (tsct_pkg::FRAC_IN - 1))) >> tsct_pkg::FRAC_IN);
          p     <= prod;
          state <= S_ADD;
        end
        S_ADD: begin
          dvd   <= p + {27'd0, rnd} + 64'(k >> 1);
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dvd  <= dvd_next;
          rem  <= rem_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCW'(DIV_STEPS - 1)) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          t <= dvd;
          if (k[0]) begin
            sin_sum <= minus ? (sin_sum - dvd) : (sin_sum + dvd);
          end else begin
            cos_sum <= minus ? (cos_sum - dvd) : (cos_sum + dvd);
          end
          if (k == kmax) begin
            state <= S_FIN;
          end else begin
            k     <= k + 1'b1;
            state <= S_MUL_LO;
          end
        end
        S_FIN: begin
          if (sel != tsct_pkg::SEL_TAN) begin
            rsp_q <= emit(sum_sel[63], sc_mag);
            state <= S_DONE;
          end else if (cos_sum == 64'd0) begin
            rsp_q.value  <= 48'd0;
            rsp_q.status <= tsct_pkg::ST_ZDIV;
            state        <= S_DONE;
          end else begin
            num   <= us;
            dvs   <= uc;
            trem  <= 64'd0;
            q     <= 48'd0;
            ovf   <= 1'b0;
            tneg  <= sin_sum[63] ^ cos_sum[63];
            tcnt  <= '0;
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          trem <= trem_next;
          num  <= {num[62:0], 1'b0};
          q    <= {q[46:0], tbit};
          ovf  <= ovf | q[47];
          tcnt <= tcnt + 1'b1;
          if (tcnt == TCW'(TDIV_LEN - 1)) begin
            state <= S_TEMIT;
          end
        end
        S_TEMIT: begin
          // A quotient of 2^20 or more saturates in either direction.
          rsp_q <= emit(tneg, (ovf | q[47]) ? (tsct_pkg::NEG_LIMIT + 64'd1)
                                             : {16'd0, q});
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);
  assign rsp       = rsp_q;

  // The request and result sides are never open together.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request and result channels open together");

  // A request transfer starts work at once.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("still ready after a request transfer");

  // A zero cosine flag belongs to a tangent request and carries a zero value.
  a_zdiv_tan: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == tsct_pkg::ST_ZDIV)
      |-> (sel == tsct_pkg::SEL_TAN && rsp.value == 48'd0))
    else $error("zero cosine status on a wrong request");

  // The term index never passes the last term.
  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> (k <= kmax && k != '0))
    else $error("term index out of range");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the series sine, cosine and tangent block.
// Drives requests, predicts each result in fixed point and checks every transfer.
// Depends on tsct_pkg and taylor_sin_cos_tan_top.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_TERMS = 15;
  // pi/2 in Q4.27, the centre of the first cosine zero.
  localparam int HALF_PI = 210828714;
  // Longest request: tangent with all sixteen terms and the quotient division.
  localparam int SLOWEST_ITEM = 12 * (2 * MAX_TERMS + 1) + 2 + 92;
  localparam int SETTLE_CYCLES = SLOWEST_ITEM + 20;
  localparam int LONG_HOLD_CYCLES = 2000;
  localparam int RANDOM_ITEMS = 1180;
  // About 1200 requests, each at worst the slowest item plus an idle gap on
  // either side; the limit allows five times their worst total.
  localparam int CYCLE_LIMIT = 3_000_000;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  tsct_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  tsct_pkg::rsp_t rsp;

  // Results still owed by the block, oldest first.
  tsct_pkg::rsp_t expected_rsps[$];
  tsct_pkg::rsp_t due;
  int mismatch_count = 0;
  int cycle_count = 0;
  // Random idling on both channels; switched off for the last stretch.
  bit idle_on = 1'b1;
  // Raised by a test to make the result side hold off for a long stretch.
  bit hold_results = 1'b0;

  taylor_sin_cos_tan_top #(.MAX_TERMS(MAX_TERMS)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  // Partial sums of the sine and cosine series in Q.32. Each term x^k/k! is
  // built from the previous one as t*|x|/k, rounding half up both in the
  // product (taken in a high and a low part) and in the division by k. The
  // sign of each term follows from its index and, for odd powers, from x.
  function automatic void series_sums(input logic signed [31:0] angle,
                                      input logic [3:0] terms,
                                      output logic signed [63:0] sin_acc,
                                      output logic signed [63:0] cos_acc);
    logic [63:0] mag_x, term, hi_part, lo_part, prod, n_eff, k;
    logic neg_term;
    mag_x = angle[31] ? 64'h1_0000_0000 - {32'd0, angle} : {32'd0, angle};
    n_eff = (terms > MAX_TERMS) ? MAX_TERMS : terms;
    term = 64'd1 << tsct_pkg::FRAC_WORK;
    sin_acc = '0;
    cos_acc = $signed(term);
    for (k = 1; k <= 2 * n_eff + 1; k++) begin
      hi_part = term >> tsct_pkg::FRAC_IN;
      lo_part = term & ((64'd1 << tsct_pkg::FRAC_IN) - 1);
      prod = hi_part * mag_x
             + ((lo_part * mag_x + (64'd1 << (tsct_pkg::FRAC_IN - 1))) >> tsct_pkg::FRAC_IN);
      term = (prod + k / 2) / k;
      neg_term = k[0] ? (k[1] ^ angle[31]) : k[1];
      if (k[0]) begin
        sin_acc = neg_term ? sin_acc - $signed(term) : sin_acc + $signed(term);
      end else begin
        cos_acc = neg_term ? cos_acc - $signed(term) : cos_acc + $signed(term);
      end
    end
  endfunction

  // The result the block owes for one request.
  function automatic tsct_pkg::rsp_t predict_rsp(input tsct_pkg::req_t item);
    logic signed [63:0] sin_acc, cos_acc, pick;
    logic [63:0] mag, num, den, quo, rem;
    logic neg;
    tsct_pkg::rsp_t res;
    res = '0;
    res.status = tsct_pkg::ST_OK;
    if (item.req_type == tsct_pkg::SEL_NONE) return res;
    series_sums(item.angle, item.term_count, sin_acc, cos_acc);
    if (item.req_type != tsct_pkg::SEL_TAN) begin
      pick = (item.req_type == tsct_pkg::SEL_SIN) ? sin_acc : cos_acc;
      neg = pick[63];
      mag = neg ? 64'd0 - pick : pick;
      // Q.32 to Q.27, magnitude rounded half up.
      mag = (mag + (64'd1 << (tsct_pkg::FRAC_WORK - tsct_pkg::FRAC_IN - 1)))
            >> (tsct_pkg::FRAC_WORK - tsct_pkg::FRAC_IN);
    end else begin
      num = sin_acc[63] ? 64'd0 - sin_acc : sin_acc;
      den = cos_acc[63] ? 64'd0 - cos_acc : cos_acc;
      neg = sin_acc[63] ^ cos_acc[63];
      if (den == 0) begin
        res.status = tsct_pkg::ST_ZDIV;
        return res;
      end
      quo = num / den;
      if (quo >= (64'd1 << 20)) begin
        // Integer part already beyond Q20: forced into saturation.
        mag = tsct_pkg::NEG_LIMIT + 1;
      end else begin
        rem = num % den;
        repeat (tsct_pkg::FRAC_IN) begin
          rem = rem << 1;
          quo = quo << 1;
          if (rem >= den) begin
            rem = rem - den;
            quo[0] = 1'b1;
          end
        end
        mag = quo;
      end
    end
    if (!neg && mag > tsct_pkg::POS_LIMIT) begin
      mag = tsct_pkg::POS_LIMIT;
      res.status = tsct_pkg::ST_SAT;
    end
    if (neg && mag > tsct_pkg::NEG_LIMIT) begin
      mag = tsct_pkg::NEG_LIMIT;
      res.status = tsct_pkg::ST_SAT;
    end
    res.value = neg ? 48'(64'd0 - mag) : mag[47:0];
    return res;
  endfunction

  // Request side. Called at a falling edge; returns at the falling edge after
  // the transfer, with valid still high so that a following request can be
  // presented at once without valid dropping in between.
  task automatic send_request(input logic [1:0] sel, input logic signed [31:0] ang,
                              input logic [3:0] terms);
    tsct_pkg::req_t item;
    item.req_type = sel;
    item.angle = ang;
    item.term_count = terms;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // Stops offering requests and waits until every owed result has arrived.
  task automatic drain_results();
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Corner angles with every function at the full term count, the shortest
  // series, and the unused selector.
  task automatic test_extremes();
    logic signed [31:0] corners [4];
    logic [1:0] sel;
    int i;
    corners = '{32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1};
    for (sel = tsct_pkg::SEL_SIN; sel <= tsct_pkg::SEL_TAN; sel++) begin
      for (i = 0; i < 4; i++) send_request(sel, corners[i], 4'hF);
    end
    send_request(tsct_pkg::SEL_SIN, HALF_PI, 4'h0);
    send_request(tsct_pkg::SEL_COS, HALF_PI, 4'h0);
    send_request(tsct_pkg::SEL_TAN, HALF_PI, 4'hF);
    send_request(tsct_pkg::SEL_NONE, 32'sh8000_0000, 4'hF);
    send_request(tsct_pkg::SEL_NONE, 32'sh7FFF_FFFF, 4'h0);
  endtask

  // Tangent next to a root of the truncated cosine series saturates, with
  // either sign of the angle. The roots are located by a coarse scan and a
  // bisection over the angle, and the few angles around each one are tried
  // for a cosine sum that is exactly zero, which gives the division by zero.
  task automatic test_tangent_poles();
    logic signed [63:0] s_acc, c_acc;
    int n, grid, lo_a, hi_a, mid, d;
    int pole_angle, pole_terms, zero_angle, zero_terms;
    bit was_pos, now_pos, found_zero;
    found_zero = 1'b0;
    pole_angle = HALF_PI;
    pole_terms = 0;
    zero_angle = 0;
    zero_terms = 0;
    for (n = 1; n <= MAX_TERMS && !found_zero; n++) begin
      was_pos = 1'b1;
      for (grid = 1; grid < 1024 && !found_zero; grid++) begin
        series_sums(grid << 21, 4'(n), s_acc, c_acc);
        now_pos = (c_acc > 0);
        if (now_pos != was_pos) begin
          lo_a = (grid - 1) << 21;
          hi_a = grid << 21;
          while (hi_a - lo_a > 1) begin
            mid = lo_a + (hi_a - lo_a) / 2;
            series_sums(mid, 4'(n), s_acc, c_acc);
            if ((c_acc > 0) == was_pos) lo_a = mid;
            else hi_a = mid;
          end
          if (pole_terms == 0) begin
            pole_angle = lo_a;
            pole_terms = n;
          end
          for (d = -64; d <= 64 && !found_zero; d++) begin
            series_sums(lo_a + d, 4'(n), s_acc, c_acc);
            if (c_acc == 0) begin
              found_zero = 1'b1;
              zero_angle = lo_a + d;
              zero_terms = n;
            end
          end
        end
        was_pos = now_pos;
      end
    end
    send_request(tsct_pkg::SEL_TAN, pole_angle, 4'(pole_terms));
    send_request(tsct_pkg::SEL_TAN, -pole_angle, 4'(pole_terms));
    if (found_zero) begin
      send_request(tsct_pkg::SEL_TAN, zero_angle, 4'(zero_terms));
      send_request(tsct_pkg::SEL_COS, -zero_angle, 4'(zero_terms));
    end
  endtask

  // The result side holds off for a long stretch while requests keep coming,
  // so the block stalls its request side; then the sender waits for all
  // results before going on.
  task automatic test_back_pressure();
    int i;
    hold_results = 1'b1;
    for (i = 0; i < 6; i++) begin
      send_request(2'($urandom_range(0, 2)), $urandom, 4'($urandom_range(0, 15)));
    end
    drain_results();
  endtask

  // Random requests. Angles are drawn from the full range, from within four
  // radians, from around multiples of pi/2 where the sums nearly cancel, and
  // from a few counts either side of zero. The last eighth runs without idling.
  task automatic test_random_mix();
    logic [1:0] sel;
    logic signed [31:0] ang;
    int i;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - RANDOM_ITEMS / 8) idle_on = 1'b0;
      sel = ($urandom_range(0, 9) == 0) ? tsct_pkg::SEL_NONE : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0: begin
          ang = $urandom;
        end
        1: begin
          ang = int'($urandom_range(0, 32'h3FFF_FFFF)) - 32'h2000_0000;
        end
        2: begin
          ang = int'($urandom_range(0, 10)) * HALF_PI + int'($urandom_range(0, 2047)) - 1024;
          if ($urandom_range(0, 1) == 1) ang = -ang;
        end
        default: begin
          ang = int'($urandom_range(0, 510)) - 255;
        end
      endcase
      send_request(sel, ang, 4'($urandom_range(0, 15)));
    end
  endtask

  // Result side: random stall bursts, or one long hold-off when a test asks
  // for it, counted here cycle by cycle.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        hold_results = 1'b0;
        stall_left = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Records the expected result of each request transfer and checks each
  // result transfer against the oldest one. Both are handled in the same
  // process so that an answer in the cycle after its request is never missed.
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) expected_rsps.push_back(predict_rsp(req));
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $error("result transfer with no request outstanding: value %0d status %0d",
               rsp.value, rsp.status);
        mismatch_count++;
      end else begin
        due = expected_rsps.pop_front();
        if (rsp.value !== due.value) begin
          $error("value: expected %0d, actual %0d", due.value, rsp.value);
          mismatch_count++;
        end
        if (rsp.status !== due.status) begin
          $error("status: expected %0d, actual %0d", due.status, rsp.status);
          mismatch_count++;
        end
      end
    end
  end

  // Guards against a hang anywhere in the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_extremes();
    test_tangent_poles();
    test_back_pressure();
    test_random_mix();
    drain_results();
    // A late or spurious result would still show up in this window.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tsct_pkg.sv
hw/rtl/taylor_sin_cos_tan_top.sv
tb/tb_top.sv
